@@ src/stcp_pkg.sv @@
`timescale 1ns / 1ps
package stcp_pkg;
  // Register stages of one stcp_mul instance.
  localparam int MUL_LAT = 4;
  // Operand slice width of the partial products.
  localparam int CHUNK = 32;
  // Radius register width (unsigned Q15.16).
  localparam int RAD_W = 31;
  // Register index, taken from paddr[2].
  localparam logic REG_RADIUS = 1'b0;
endpackage

@@ src/stcp_dly.sv @@
`timescale 1ns / 1ps
module stcp_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int k = 1; k < N; k++) sr[k] <= sr[k-1];
  end

  assign q = sr[N-1];
endmodule

@@ src/stcp_mul.sv @@
`timescale 1ns / 1ps
module stcp_mul
  import stcp_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  localparam int NA = (AW + CHUNK - 1) / CHUNK;
  localparam int NB = (BW + CHUNK - 1) / CHUNK;
  localparam int PW = AW + BW;

  logic [NA*CHUNK-1:0] amag;
  logic [NB*CHUNK-1:0] bmag;
  logic                neg1, neg2, neg3;
  logic [2*CHUNK-1:0]  part [NA][NB];
  logic [PW-1:0]       row [NA];
  logic [PW-1:0]       row_next [NA];
  logic [PW-1:0]       tot;

  // sign-magnitude: 32x32 slices, row sums, then final sum and sign
  always_ff @(posedge clk) begin
    amag <= (NA*CHUNK)'($unsigned(a[AW-1] ? -a : a));
    bmag <= (NB*CHUNK)'($unsigned(b[BW-1] ? -b : b));
    neg1 <= a[AW-1] ^ b[BW-1];
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        part[i][j] <= amag[i*CHUNK +: CHUNK] * bmag[j*CHUNK +: CHUNK];
      end
    end
    neg2 <= neg1;
    row  <= row_next;
    neg3 <= neg2;
    p    <= neg3 ? -$signed(tot) : $signed(tot);
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(part[i][j]) << (j*CHUNK));
      end
    end
  end

  always_comb begin
    tot = '0;
    for (int i = 0; i < NA; i++) tot = tot + (row[i] << (i*CHUNK));
  end
endmodule

@@ src/stcp_div.sv @@
`timescale 1ns / 1ps
module stcp_div #(
  parameter int VW = 139,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic signed [VW-1:0] num,
  input  logic signed [VW-1:0] den,
  output logic [FB:0]          q
);
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic [VW:0]   rem [FB];
  logic [VW-1:0] dv  [FB];
  logic          fix [FB];
  logic [FB:0]   qv  [FB+1];
  logic [VW:0]   sh  [FB];
  logic          ge  [FB];

  // entry: non-positive operands give 0, num >= den gives one
  always_ff @(posedge clk) begin
    rem[0] <= (VW+1)'($unsigned(num));
    dv[0]  <= $unsigned(den);
    priority if (den <= 0 || num <= 0) begin
      fix[0] <= 1'b1;
      qv[0]  <= '0;
    end else if (num >= den) begin
      fix[0] <= 1'b1;
      qv[0]  <= ONE;
    end else begin
      fix[0] <= 1'b0;
      qv[0]  <= '0;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < FB; k++) begin : g_step
    always_comb begin
      sh[k] = rem[k] << 1;
      ge[k] = sh[k] >= {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      qv[k+1] <= fix[k] ? qv[k] : {qv[k][FB-1:0], ge[k]};
    end

    if (k < FB - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem[k+1] <= ge[k] ? (sh[k] - {1'b0, dv[k]}) : sh[k];
        dv[k+1]  <= dv[k];
        fix[k+1] <= fix[k];
      end
    end
  end

  assign q = qv[FB];
endmodule

@@ src/sphere_triangle_closest_point_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                          Handshake
// request   query_*, vert0_*, vert1_*, vert2_*             start, busy (taken: start & !busy)
// result    hit, near_x, near_y, near_z                    done, one cycle, no back-pressure
// config    psel penable pwrite paddr pwdata prdata pready APB, pready tied high
//
// Fully pipelined: one request per clock, busy stays low.
// Latency from accept edge to done is set by the four multiplier passes (dots, cross
// terms, weighting, distance) and the one-bit-per-stage weight divider.
// Synchronous active-high reset clears the valid chain and sets the radius to 1.0.
// Users must land radius writes while the pipe is empty (unenforced); rr follows next cycle.
module sphere_triangle_closest_point_unit
  import stcp_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] query_x,
  input  logic [COORD_WIDTH-1:0] query_y,
  input  logic [COORD_WIDTH-1:0] query_z,
  input  logic [COORD_WIDTH-1:0] vert0_x,
  input  logic [COORD_WIDTH-1:0] vert0_y,
  input  logic [COORD_WIDTH-1:0] vert0_z,
  input  logic [COORD_WIDTH-1:0] vert1_x,
  input  logic [COORD_WIDTH-1:0] vert1_y,
  input  logic [COORD_WIDTH-1:0] vert1_z,
  input  logic [COORD_WIDTH-1:0] vert2_x,
  input  logic [COORD_WIDTH-1:0] vert2_y,
  input  logic [COORD_WIDTH-1:0] vert2_z,
  output logic                   done,
  output logic                   hit,
  output logic [COORD_WIDTH-1:0] near_x,
  output logic [COORD_WIDTH-1:0] near_y,
  output logic [COORD_WIDTH-1:0] near_z,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int EW   = CW + 1;          // edge / offset vectors
  localparam int DW   = 2 * EW + 2;      // dot products
  localparam int XW   = 2 * DW + 1;      // cross terms va, vb, vc
  localparam int VW   = XW + 2;          // divider operands
  localparam int WW   = FB + 2;          // signed weight
  localparam int PW   = WW + EW;         // weight times edge
  localparam int SW   = PW + 2;          // near point before clamp
  localparam int QW   = 2 * EW + 2;      // squared distance
  localparam int RW   = 2 * RAD_W;
  localparam int CMPW = (QW > RW ? QW : RW) + 1;
  localparam int DL   = FB + 1;
  localparam int LAT  = 7 + 4 * MUL_LAT + DL;
  localparam int GW   = 12 * CW + 9 * EW;
  localparam int BW2  = 6 * CW + 6 * EW;
  localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  // ---------------- configuration ----------------
  logic [RAD_W-1:0] radius;
  logic [RW-1:0]    rr;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_W'(65536);
    end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
      radius <= pwdata[RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rr <= RW'(radius) * RW'(radius);
  end

  assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius) : '0;

  // ---------------- valid chain ----------------
  logic [LAT-2:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAT-3:0], start & ~busy};
      done <= vld[LAT-2];
    end
  end

  // ---------------- input and edge vectors ----------------
  logic [2:0][CW-1:0] qin, v0, v1, v2;
  logic [2:0][CW-1:0] p0_s2, p1_s2, p2_s2, q_s2;
  logic [2:0][EW-1:0] ab, ac, bc, ap, bp, cp;

  always_ff @(posedge clk) begin
    qin <= {query_z, query_y, query_x};
    v0  <= {vert0_z, vert0_y, vert0_x};
    v1  <= {vert1_z, vert1_y, vert1_x};
    v2  <= {vert2_z, vert2_y, vert2_x};
    p0_s2 <= v0;
    p1_s2 <= v1;
    p2_s2 <= v2;
    q_s2  <= qin;
    for (int i = 0; i < 3; i++) begin
      ab[i] <= EW'($signed(v1[i])) - EW'($signed(v0[i]));
      ac[i] <= EW'($signed(v2[i])) - EW'($signed(v0[i]));
      bc[i] <= EW'($signed(v2[i])) - EW'($signed(v1[i]));
      ap[i] <= EW'($signed(qin[i])) - EW'($signed(v0[i]));
      bp[i] <= EW'($signed(qin[i])) - EW'($signed(v1[i]));
      cp[i] <= EW'($signed(qin[i])) - EW'($signed(v2[i]));
    end
  end

  // ---------------- six dot products ----------------
  // d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
  logic signed [EW-1:0]   dl [6][3];
  logic signed [EW-1:0]   dr [6][3];
  logic signed [2*EW-1:0] dp [6][3];
  logic [5:0][DW-1:0]     dot;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        dl[k][i] = $signed((k % 2 == 0) ? ab[i] : ac[i]);
        dr[k][i] = $signed((k / 2 == 0) ? ap[i] : ((k / 2 == 1) ? bp[i] : cp[i]));
      end
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      stcp_mul #(.AW(EW), .BW(EW)) u_mul (
        .clk (clk),
        .a   (dl[k][i]),
        .b   (dr[k][i]),
        .p   (dp[k][i])
      );
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      dot[k] <= DW'(dp[k][0]) + DW'(dp[k][1]) + DW'(dp[k][2]);
    end
  end

  // ---------------- cross terms ----------------
  logic signed [2*DW-1:0] xp [6];
  logic signed [XW-1:0]   va, vb, vc;

  stcp_mul #(.AW(DW), .BW(DW)) u_x0 (.clk(clk), .a($signed(dot[0])), .b($signed(dot[3])),
                                     .p(xp[0]));
  stcp_mul #(.AW(DW), .BW(DW)) u_x1 (.clk(clk), .a($signed(dot[2])), .b($signed(dot[1])),
                                     .p(xp[1]));
  stcp_mul #(.AW(DW), .BW(DW)) u_x2 (.clk(clk), .a($signed(dot[4])), .b($signed(dot[1])),
                                     .p(xp[2]));
  stcp_mul #(.AW(DW), .BW(DW)) u_x3 (.clk(clk), .a($signed(dot[0])), .b($signed(dot[5])),
                                     .p(xp[3]));
  stcp_mul #(.AW(DW), .BW(DW)) u_x4 (.clk(clk), .a($signed(dot[2])), .b($signed(dot[5])),
                                     .p(xp[4]));
  stcp_mul #(.AW(DW), .BW(DW)) u_x5 (.clk(clk), .a($signed(dot[4])), .b($signed(dot[3])),
                                     .p(xp[5]));

  always_ff @(posedge clk) begin
    vc <= XW'(xp[0]) - XW'(xp[1]);
    vb <= XW'(xp[2]) - XW'(xp[3]);
    va <= XW'(xp[4]) - XW'(xp[5]);
  end

  // dots and geometry catch up with the cross terms
  logic [5:0][DW-1:0] dd;
  logic [GW-1:0]      geo;
  logic [2:0][CW-1:0] g_p0, g_p1, g_p2, g_q;
  logic [2:0][EW-1:0] g_ab, g_ac, g_bc;

  stcp_dly #(.W(6*DW), .N(MUL_LAT+1)) u_dly_dot (.clk(clk), .d(dot), .q(dd));
  stcp_dly #(.W(GW), .N(2*MUL_LAT+2)) u_dly_geo (
    .clk (clk),
    .d   ({p0_s2, p1_s2, p2_s2, q_s2, ab, ac, bc}),
    .q   (geo)
  );
  assign {g_p0, g_p1, g_p2, g_q, g_ab, g_ac, g_bc} = geo;

  // ---------------- region select ----------------
  // Vertex regions give a zero numerator, edge regions a zero second weight,
  // so one weighted sum covers every case.
  logic signed [DW-1:0] d [6];
  logic signed [DW:0]   e1, e2;
  logic signed [VW-1:0] num1, den1, num2, den2;
  logic [2:0][CW-1:0]   base;
  logic [2:0][EW-1:0]   dir;

  always_comb begin
    for (int k = 0; k < 6; k++) d[k] = $signed(dd[k]);
    e1   = (DW+1)'(d[3]) - (DW+1)'(d[2]);
    e2   = (DW+1)'(d[4]) - (DW+1)'(d[5]);
    num1 = '0;
    den1 = '0;
    num2 = '0;
    den2 = '0;
    base = g_p0;
    dir  = g_ab;
    priority if (d[0] <= 0 && d[1] <= 0) begin
      base = g_p0;
    end else if (d[2] >= 0 && d[3] <= d[2]) begin
      base = g_p1;
    end else if (vc <= 0 && d[0] >= 0 && d[2] <= 0) begin
      num1 = VW'(d[0]);
      den1 = VW'(d[0]) - VW'(d[2]);
    end else if (d[5] >= 0 && d[4] <= d[5]) begin
      base = g_p2;
    end else if (vb <= 0 && d[1] >= 0 && d[5] <= 0) begin
      num1 = VW'(d[1]);
      den1 = VW'(d[1]) - VW'(d[5]);
      dir  = g_ac;
    end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      num1 = VW'(e1);
      den1 = VW'(e1) + VW'(e2);
      base = g_p1;
      dir  = g_bc;
    end else begin
      num1 = VW'(vb);
      den1 = VW'(va) + VW'(vb) + VW'(vc);
      num2 = VW'(vc);
      den2 = VW'(va) + VW'(vb) + VW'(vc);
    end
  end

  logic signed [VW-1:0] n1, dn1, n2, dn2;
  logic [2:0][CW-1:0]   rbase, rq;
  logic [2:0][EW-1:0]   rdir, rac;

  always_ff @(posedge clk) begin
    n1    <= num1;
    dn1   <= den1;
    n2    <= num2;
    dn2   <= den2;
    rbase <= base;
    rdir  <= dir;
    rac   <= g_ac;
    rq    <= g_q;
  end

  // ---------------- weights ----------------
  logic [FB:0]        q1, q2;
  logic [BW2-1:0]     side;
  logic [2:0][CW-1:0] w_base, w_q;
  logic [2:0][EW-1:0] w_dir, w_ac;

  stcp_div #(.VW(VW), .FB(FB)) u_div1 (.clk(clk), .num(n1), .den(dn1), .q(q1));
  stcp_div #(.VW(VW), .FB(FB)) u_div2 (.clk(clk), .num(n2), .den(dn2), .q(q2));
  stcp_dly #(.W(BW2), .N(DL)) u_dly_w (
    .clk (clk),
    .d   ({rbase, rdir, rac, rq}),
    .q   (side)
  );
  assign {w_base, w_dir, w_ac, w_q} = side;

  // ---------------- weighted offsets ----------------
  logic signed [WW-1:0] tw, uw;
  logic signed [PW-1:0] pt [3];
  logic signed [PW-1:0] pu [3];
  logic [2:0][CW-1:0]   m_base, m_q;

  assign tw = $signed({1'b0, q1});
  assign uw = $signed({1'b0, q2});

  for (genvar i = 0; i < 3; i++) begin : g_wt
    stcp_mul #(.AW(WW), .BW(EW)) u_mt (.clk(clk), .a(tw), .b($signed(w_dir[i])), .p(pt[i]));
    stcp_mul #(.AW(WW), .BW(EW)) u_mu (.clk(clk), .a(uw), .b($signed(w_ac[i])), .p(pu[i]));
  end

  stcp_dly #(.W(6*CW), .N(MUL_LAT)) u_dly_m (
    .clk (clk),
    .d   ({w_base, w_q}),
    .q   ({m_base, m_q})
  );

  // ---------------- near point, clamped ----------------
  logic signed [SW-1:0] sv [3];
  logic [2:0][CW-1:0]   nr, nq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = ((SW'(pt[i]) + SW'(pu[i])) >>> FB) + SW'($signed(m_base[i]));
    end
  end

  always_ff @(posedge clk) begin
    nq <= m_q;
    for (int i = 0; i < 3; i++) begin
      priority if (sv[i] > MAXV) begin
        nr[i] <= MAXV[CW-1:0];
      end else if (sv[i] < MINV) begin
        nr[i] <= MINV[CW-1:0];
      end else begin
        nr[i] <= sv[i][CW-1:0];
      end
    end
  end

  // ---------------- squared distance ----------------
  logic signed [EW-1:0]   df [3];
  logic signed [2*EW-1:0] sq [3];
  logic [2:0][CW-1:0]     f_nr;
  logic signed [QW-1:0]   sq_dist;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign df[i] = EW'($signed(nr[i])) - EW'($signed(nq[i]));
    stcp_mul #(.AW(EW), .BW(EW)) u_ms (.clk(clk), .a(df[i]), .b(df[i]), .p(sq[i]));
  end

  stcp_dly #(.W(3*CW), .N(MUL_LAT)) u_dly_f (.clk(clk), .d(nr), .q(f_nr));

  assign sq_dist = QW'(sq[0]) + QW'(sq[1]) + QW'(sq[2]);

  always_ff @(posedge clk) begin
    hit    <= CMPW'(sq_dist) <= CMPW'(rr);
    near_x <= f_nr[0];
    near_y <= f_nr[1];
    near_z <= f_nr[2];
  end

`ifndef SYNTH
  // every accepted request comes out after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result strobe missing after fixed latency");

  // weights never exceed one; checked in the cycle a valid request sits at the divider outputs
  a_wt_range : assert property (@(posedge clk) disable iff (rst)
    vld[4 + 2 * MUL_LAT + DL] |->
      (tw <= $signed({2'b01, {FB{1'b0}}})) && (uw <= $signed({2'b01, {FB{1'b0}}})))
    else $error("weight above one");

  // second weight is only armed in the interior case, with the shared divisor
  a_interior : assert property (@(posedge clk) disable iff (rst)
    (n2 != '0) |-> (dn2 == dn1 && n1 != '0 || dn2 == dn1))
    else $error("second divisor differs from first");
`endif
endmodule
